// ===== rtl/rcm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared types and constants of the R-hat convergence monitor.
// ----------------------------------------------------------------------------
package rcm_pkg;

	localparam int X_W      = 48;   // Q32.16 sample and mean width
	localparam int IDX_W    = 6;    // chain_index field width
	localparam int THR_W    = 26;
	localparam int DRAWS_W  = 20;
	localparam int CHAINS_W = 7;
	localparam int CFG_W    = 26;   // widest register
	localparam int CFGI_W   = 2;
	localparam int RHAT_W   = 32;
	localparam int TOTAL_W  = 27;
	localparam int EVAL_W   = 32;

	localparam int NUM_W    = 128;  // divider numerator / quotient
	localparam int DEN_W    = 64;   // divider divisor
	localparam int MUL_W    = 49;   // magnitude of a 48-bit difference
	localparam int PROD_W   = 2 * MUL_W;
	localparam int SQ_IT    = 32;   // 64-bit root, two bits per step

	localparam logic [7:0] DIV_IT_SHORT = 8'd49;
	localparam logic [7:0] DIV_IT_HALF  = 8'd64;
	localparam logic [7:0] DIV_IT_FULL  = 8'd128;

	localparam logic OP_OBSERVE  = 1'b0;
	localparam logic OP_EVALUATE = 1'b1;

	localparam logic [CFGI_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFGI_W-1:0] REG_MAX_DRAWS = 2'd1;
	localparam logic [CFGI_W-1:0] REG_CHAINS    = 2'd2;

	localparam logic [THR_W-1:0]    THRESHOLD_RST = 26'd16778893;
	localparam logic [DRAWS_W-1:0]  MAX_DRAWS_RST = 20'd100000;
	localparam logic [CHAINS_W-1:0] CHAINS_RST    = 7'd64;

	localparam logic [63:0] ONE_Q48   = 64'h0001_0000_0000_0000;
	localparam logic [63:0] T_LIMIT   = 64'hFFFE_FFFF_FFFF_FFFF;
	localparam logic [63:0] SQ_BIT0   = 64'h4000_0000_0000_0000;

	typedef enum logic [2:0] {
		DIV_OBS,
		DIV_MM,
		DIV_S2,
		DIV_VM,
		DIV_MV,
		DIV_T
	} div_sel_t;

	typedef enum logic {
		MUL_OBS,
		MUL_DM
	} mul_sel_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_O_RD,
		S_O_DIV,
		S_O_MST,
		S_O_MUL,
		S_E1_RD,
		S_E1_ACC,
		S_E1_END,
		S_E_MM,
		S_E2_RD,
		S_E2_ST,
		S_E2_WT,
		S_E_VM,
		S_E_VMW,
		S_E_MV,
		S_E_MVW,
		S_E_CHK,
		S_E_TW,
		S_E_TCHK,
		S_E_SQ,
		S_FIN
	} state_t;

	typedef struct packed {
		logic     capture;
		logic     ram_rd;
		logic     idx_clr;
		logic     idx_inc;
		logic     acc_clr;
		logic     p1_acc;
		logic     div_start;
		div_sel_t div_sel;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     mean_upd;
		logic     obs_write;
		logic     mm_latch;
		logic     p2_acc;
		logic     vm_latch;
		logic     mv_latch;
		logic     t_latch;
		logic     rhat_sat;
		logic     sqrt_start;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic obs_ign;
		logic rd_full;
		logic idx_last;
		logic div_busy;
		logic mul_busy;
		logic sqrt_busy;
		logic ev_valid;
		logic vm_big;
		logic t_big;
		logic out_busy;
	} status_t;

endpackage

// ===== rtl/rcm_in_if.sv =====
// ----------------------------------------------------------------------------
// rcm_in_if
// Input channel: one observe or evaluate word per handshake.
// ----------------------------------------------------------------------------
interface rcm_in_if;
	logic              valid;
	logic              ready;
	logic              operation;
	logic [5:0]        chain_index;
	logic signed [47:0] sample_x;

	modport source (output valid, output operation, output chain_index,
		output sample_x, input ready);
	modport sink (input valid, input operation, input chain_index,
		input sample_x, output ready);
endinterface

// ===== rtl/rcm_out_if.sv =====
// ----------------------------------------------------------------------------
// rcm_out_if
// Result channel: one word per evaluate.
// ----------------------------------------------------------------------------
interface rcm_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] r_hat;
	logic        r_hat_valid;
	logic [26:0] total_draws;
	logic        stop;
	logic [31:0] eval_count;

	modport source (output valid, output r_hat, output r_hat_valid,
		output total_draws, output stop, output eval_count, input ready);
	modport sink (input valid, input r_hat, input r_hat_valid,
		input total_draws, input stop, input eval_count, output ready);
endinterface

// ===== rtl/rcm_ram.sv =====
// ----------------------------------------------------------------------------
// rcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/rcm_div.sv =====
// ----------------------------------------------------------------------------
// rcm_div
// Restoring radix-2 divider, one quotient bit per cycle. The numerator is
// given left aligned; iters sets how many of its top bits are consumed.
// ----------------------------------------------------------------------------
module rcm_div import rcm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [7:0]       iters,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [7:0]       cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   rem2;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign rem2 = {rem_q, num_q[NUM_W-1]};
	assign diff = rem2 - {1'b0, den_q};
	assign ge   = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 8'd1;
			if (cnt_q == 8'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/rcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcm_ctrl
// Sequencer for observe updates and the two-pass evaluate walk.
// ----------------------------------------------------------------------------
module rcm_ctrl import rcm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  status_t st,
	output logic    item_ready,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (item_valid) state_d = S_DECODE;
			S_DECODE: begin
				if (st.op == OP_OBSERVE) begin
					state_d = st.obs_ign ? S_IDLE : S_O_RD;
				end else begin
					state_d = S_E1_RD;
				end
			end
			S_O_RD:  state_d = st.rd_full ? S_IDLE : S_O_DIV;
			S_O_DIV: if (!st.div_busy) state_d = S_O_MST;
			S_O_MST: state_d = S_O_MUL;
			S_O_MUL: if (!st.mul_busy) state_d = S_IDLE;
			S_E1_RD:  state_d = S_E1_ACC;
			S_E1_ACC: state_d = st.idx_last ? S_E1_END : S_E1_RD;
			S_E1_END: state_d = st.ev_valid ? S_E_MM : S_FIN;
			S_E_MM:  if (!st.div_busy) state_d = S_E2_RD;
			S_E2_RD: state_d = S_E2_ST;
			S_E2_ST: state_d = S_E2_WT;
			S_E2_WT: begin
				if (!st.div_busy && !st.mul_busy) begin
					state_d = st.idx_last ? S_E_VM : S_E2_RD;
				end
			end
			S_E_VM:  state_d = S_E_VMW;
			S_E_VMW: if (!st.div_busy) state_d = S_E_MV;
			S_E_MV:  state_d = S_E_MVW;
			S_E_MVW: if (!st.div_busy) state_d = S_E_CHK;
			S_E_CHK: begin
				if (!st.ev_valid || st.vm_big) begin
					state_d = S_FIN;
				end else begin
					state_d = S_E_TW;
				end
			end
			S_E_TW:   if (!st.div_busy) state_d = S_E_TCHK;
			S_E_TCHK: state_d = st.t_big ? S_FIN : S_E_SQ;
			S_E_SQ:   if (!st.sqrt_busy) state_d = S_FIN;
			S_FIN:    if (!st.out_busy) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
			end
			S_DECODE: begin
				if (st.op == OP_OBSERVE) begin
					cmd.ram_rd = !st.obs_ign;
				end else begin
					cmd.idx_clr = 1'b1;
					cmd.acc_clr = 1'b1;
				end
			end
			S_O_RD: begin
				cmd.div_start = !st.rd_full;
				cmd.div_sel   = DIV_OBS;
			end
			S_O_DIV: cmd.mean_upd = !st.div_busy;
			S_O_MST: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MUL_OBS;
			end
			S_O_MUL: cmd.obs_write = !st.mul_busy;
			S_E1_RD: cmd.ram_rd = 1'b1;
			S_E1_ACC: begin
				cmd.p1_acc  = 1'b1;
				cmd.idx_inc = !st.idx_last;
			end
			S_E1_END: begin
				cmd.div_start = st.ev_valid;
				cmd.div_sel   = DIV_MM;
			end
			S_E_MM: begin
				cmd.mm_latch = !st.div_busy;
				cmd.idx_clr  = !st.div_busy;
			end
			S_E2_RD: cmd.ram_rd = 1'b1;
			S_E2_ST: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MUL_DM;
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_S2;
			end
			S_E2_WT: begin
				if (!st.div_busy && !st.mul_busy) begin
					cmd.p2_acc  = 1'b1;
					cmd.idx_inc = !st.idx_last;
				end
			end
			S_E_VM: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_VM;
			end
			S_E_VMW: cmd.vm_latch = !st.div_busy;
			S_E_MV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_MV;
			end
			S_E_MVW: cmd.mv_latch = !st.div_busy;
			S_E_CHK: begin
				if (st.ev_valid && st.vm_big) begin
					cmd.rhat_sat = 1'b1;
				end else if (st.ev_valid) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_T;
				end
			end
			S_E_TW: cmd.t_latch = !st.div_busy;
			S_E_TCHK: begin
				cmd.rhat_sat   = st.t_big;
				cmd.sqrt_start = !st.t_big;
			end
			S_FIN: cmd.finish = !st.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/rcm_dp.sv =====
// ----------------------------------------------------------------------------
// rcm_dp
// Datapath: per-chain statistics memories, configuration registers,
// evaluate accumulators, shift-add multiplier, shared divider and root.
// ----------------------------------------------------------------------------
module rcm_dp import rcm_pkg::*; #(
	parameter int MAX_CHAINS = 64,
	parameter int COUNT_BITS = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFGI_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_operation,
	input  logic [IDX_W-1:0]     in_chain_index,
	input  logic signed [X_W-1:0] in_sample_x,
	input  logic                 res_ready,
	output logic                 res_valid,
	output logic [RHAT_W-1:0]    res_r_hat,
	output logic                 res_r_hat_valid,
	output logic [TOTAL_W-1:0]   res_total_draws,
	output logic                 res_stop,
	output logic [EVAL_W-1:0]    res_eval_count,
	input  cmd_t                 cmd,
	output status_t              st
);

	localparam int CW  = $clog2(MAX_CHAINS);
	localparam int MW  = $clog2(MAX_CHAINS + 1);
	localparam int MSW = X_W + CW + 1;
	localparam int SVW = 64 + CW;

	// configuration
	logic [THR_W-1:0]    thr_q;
	logic [DRAWS_W-1:0]  max_draws_q;
	logic [CHAINS_W-1:0] chains_q;
	logic [MW-1:0]       m_act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THRESHOLD_RST;
			max_draws_q <= MAX_DRAWS_RST;
			chains_q    <= CHAINS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q       <= cfg_wdata[THR_W-1:0];
				REG_MAX_DRAWS: max_draws_q <= cfg_wdata[DRAWS_W-1:0];
				REG_CHAINS:    chains_q    <= cfg_wdata[CHAINS_W-1:0];
				default:       thr_q       <= thr_q;
			endcase
		end
	end

	always_comb begin
		if (32'(chains_q) < 32'd2) begin
			m_act = MW'(2);
		end else if (32'(chains_q) > 32'(MAX_CHAINS)) begin
			m_act = MW'(MAX_CHAINS);
		end else begin
			m_act = MW'(chains_q);
		end
	end

	// captured input word
	logic                  op_q;
	logic [IDX_W-1:0]      chain_q;
	logic signed [X_W-1:0] x_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= in_operation;
			chain_q <= in_chain_index;
			x_q     <= in_sample_x;
		end
	end

	// chain index walk
	logic [CW-1:0] idx_q;

	always_ff @(posedge clk) begin
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	// statistics memories; a never-written entry reads as zero
	logic [CW-1:0]         chain_addr;
	logic [CW-1:0]         rd_addr;
	logic [MAX_CHAINS-1:0] vld_q;
	logic                  rd_vld_q;
	logic [COUNT_BITS-1:0] ram_cnt, cnt_rd, cnt_wr;
	logic [X_W-1:0]        ram_mean, mean_wr;
	logic [63:0]           ram_sq, sq_rd, sq_wr;
	logic signed [X_W-1:0] mean_rd;

	assign chain_addr = CW'(chain_q);
	assign rd_addr    = (op_q == OP_OBSERVE) ? chain_addr : idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.obs_write) begin
				vld_q[chain_addr] <= 1'b1;
			end
			if (cmd.ram_rd) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	rcm_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_CHAINS)) u_cnt_ram (
		.clk(clk), .we(cmd.obs_write), .waddr(chain_addr), .wdata(cnt_wr),
		.re(cmd.ram_rd), .raddr(rd_addr), .rdata(ram_cnt)
	);
	rcm_ram #(.WIDTH(X_W), .DEPTH(MAX_CHAINS)) u_mean_ram (
		.clk(clk), .we(cmd.obs_write), .waddr(chain_addr), .wdata(mean_wr),
		.re(cmd.ram_rd), .raddr(rd_addr), .rdata(ram_mean)
	);
	rcm_ram #(.WIDTH(64), .DEPTH(MAX_CHAINS)) u_sq_ram (
		.clk(clk), .we(cmd.obs_write), .waddr(chain_addr), .wdata(sq_wr),
		.re(cmd.ram_rd), .raddr(rd_addr), .rdata(ram_sq)
	);

	assign cnt_rd  = rd_vld_q ? ram_cnt : '0;
	assign mean_rd = rd_vld_q ? $signed(ram_mean) : '0;
	assign sq_rd   = rd_vld_q ? ram_sq : '0;

	logic chain_full;
	logic [COUNT_BITS:0] n_obs;

	assign chain_full = (32'(cnt_rd) >= 32'(max_draws_q)) || (&cnt_rd);
	assign n_obs      = {1'b0, cnt_rd} + (COUNT_BITS+1)'(1);

	// observe operands
	logic [X_W:0]   d_sub, d_abs;
	logic [X_W:0]   d2_sub, d2_abs;
	logic           d_neg_q;
	logic [X_W:0]   d_mag_q;
	logic [X_W-1:0] mean_new_q;
	logic [X_W:0]   q_obs, delta;

	assign d_sub  = {x_q[X_W-1], x_q} - {mean_rd[X_W-1], mean_rd};
	assign d_abs  = d_sub[X_W] ? (~d_sub + 1'b1) : d_sub;
	assign d2_sub = {x_q[X_W-1], x_q} - {mean_new_q[X_W-1], mean_new_q};
	assign d2_abs = d2_sub[X_W] ? (~d2_sub + 1'b1) : d2_sub;

	// evaluate accumulators
	logic [TOTAL_W-1:0]    total_q;
	logic signed [MSW-1:0] msum_q;
	logic [MSW-1:0]        msum_mag;
	logic                  all_full_q;
	logic                  ev_valid_q;
	logic [X_W-1:0]        mm_q;
	logic [NUM_W-1:0]      ss_q;
	logic [SVW-1:0]        sv_q;
	logic [NUM_W-1:0]      vm_q;
	logic [63:0]           mv_q;
	logic [NUM_W-1:0]      t_q;
	logic [RHAT_W-1:0]     rhat_q;
	logic [X_W:0]          dm_sub, dm_abs;
	logic [X_W-1:0]        q_mm;

	assign msum_mag = msum_q[MSW-1] ? MSW'(-msum_q) : MSW'(msum_q);
	assign dm_sub   = {mean_rd[X_W-1], mean_rd} - {mm_q[X_W-1], mm_q};
	assign dm_abs   = dm_sub[X_W] ? (~dm_sub + 1'b1) : dm_sub;

	// divider
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic [7:0]       div_it;
	logic             div_busy;
	logic [NUM_W-1:0] quo;

	always_comb begin
		case (cmd.div_sel)
			DIV_OBS: begin
				div_num = {d_abs, {(NUM_W-X_W-1){1'b0}}};
				div_den = DEN_W'(n_obs);
				div_it  = DIV_IT_SHORT;
			end
			DIV_MM: begin
				div_num = {64'(msum_mag), 64'd0};
				div_den = DEN_W'(m_act);
				div_it  = DIV_IT_HALF;
			end
			DIV_S2: begin
				div_num = {sq_rd, 64'd0};
				div_den = DEN_W'(cnt_rd - COUNT_BITS'(1));
				div_it  = DIV_IT_HALF;
			end
			DIV_VM: begin
				div_num = ss_q;
				div_den = DEN_W'(m_act - MW'(1));
				div_it  = DIV_IT_FULL;
			end
			DIV_MV: begin
				div_num = NUM_W'(sv_q);
				div_den = DEN_W'(m_act);
				div_it  = DIV_IT_FULL;
			end
			DIV_T: begin
				div_num = {vm_q[95:0], 32'd0};
				div_den = mv_q;
				div_it  = DIV_IT_FULL;
			end
			default: begin
				div_num = ss_q;
				div_den = mv_q;
				div_it  = DIV_IT_FULL;
			end
		endcase
	end

	rcm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(div_num),
		.den(div_den), .iters(div_it), .busy(div_busy), .quo(quo)
	);

	assign q_obs = quo[X_W:0];
	assign delta = d_neg_q ? (~q_obs + 1'b1) : q_obs;
	assign q_mm  = quo[X_W-1:0];

	// shift-add multiplier, one multiplier bit per cycle
	logic [MUL_W-1:0]  mul_a_q;
	logic [PROD_W-1:0] mul_b_q, mul_p_q;
	logic [5:0]        mul_cnt_q;
	logic              mul_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_cnt_q  <= '0;
		end else if (cmd.mul_start) begin
			mul_busy_q <= 1'b1;
			mul_cnt_q  <= 6'(MUL_W);
		end else if (mul_busy_q) begin
			mul_cnt_q <= mul_cnt_q - 6'd1;
			if (mul_cnt_q == 6'd1) begin
				mul_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mul_p_q <= '0;
			if (cmd.mul_sel == MUL_OBS) begin
				mul_a_q <= d_mag_q;
				mul_b_q <= PROD_W'(d2_abs);
			end else begin
				mul_a_q <= dm_abs;
				mul_b_q <= PROD_W'(dm_abs);
			end
		end else if (mul_busy_q) begin
			if (mul_a_q[0]) begin
				mul_p_q <= mul_p_q + mul_b_q;
			end
			mul_a_q <= mul_a_q >> 1;
			mul_b_q <= mul_b_q << 1;
		end
	end

	// observe write-back, sum of squares saturates
	logic [63:0] sq_inc;
	logic [64:0] sq_sum;

	assign sq_inc  = (|mul_p_q[PROD_W-1:80]) ? '1 : mul_p_q[79:16];
	assign sq_sum  = {1'b0, sq_rd} + {1'b0, sq_inc};
	assign sq_wr   = sq_sum[64] ? '1 : sq_sum[63:0];
	assign cnt_wr  = COUNT_BITS'(n_obs);
	assign mean_wr = mean_new_q;

	// integer square root, two bits per cycle
	logic [63:0] sq_v_q, sq_res_q, sq_bit_q;
	logic [63:0] sq_trial, sq_res_nx;
	logic [5:0]  sq_cnt_q;
	logic        sq_busy_q;
	logic        sq_take;

	assign sq_trial  = sq_res_q + sq_bit_q;
	assign sq_take   = sq_v_q >= sq_trial;
	assign sq_res_nx = sq_take ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_cnt_q  <= '0;
		end else if (cmd.sqrt_start) begin
			sq_busy_q <= 1'b1;
			sq_cnt_q  <= 6'(SQ_IT);
		end else if (sq_busy_q) begin
			sq_cnt_q <= sq_cnt_q - 6'd1;
			if (sq_cnt_q == 6'd1) begin
				sq_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sq_v_q   <= t_q[63:0] + ONE_Q48;
			sq_res_q <= '0;
			sq_bit_q <= SQ_BIT0;
		end else if (sq_busy_q) begin
			if (sq_take) begin
				sq_v_q <= sq_v_q - sq_trial;
			end
			sq_res_q <= sq_res_nx;
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// datapath payload registers
	always_ff @(posedge clk) begin
		if (cmd.div_start && cmd.div_sel == DIV_OBS) begin
			d_neg_q <= d_sub[X_W];
			d_mag_q <= d_abs;
		end
		if (cmd.mean_upd) begin
			mean_new_q <= mean_rd + delta[X_W-1:0];
		end
		if (cmd.acc_clr) begin
			total_q    <= '0;
			msum_q     <= '0;
			all_full_q <= 1'b1;
			ev_valid_q <= 1'b1;
			ss_q       <= '0;
			sv_q       <= '0;
			rhat_q     <= '0;
		end else begin
			if (cmd.p1_acc) begin
				total_q    <= total_q + TOTAL_W'(cnt_rd);
				msum_q     <= msum_q + MSW'(mean_rd);
				all_full_q <= all_full_q & chain_full;
				ev_valid_q <= ev_valid_q & (cnt_rd >= COUNT_BITS'(2));
			end
			if (cmd.p2_acc) begin
				ss_q <= ss_q + NUM_W'(mul_p_q);
				sv_q <= sv_q + SVW'(quo[63:0]);
			end
			if (cmd.mv_latch) begin
				ev_valid_q <= ev_valid_q & (|quo[63:0]);
			end
			if (cmd.rhat_sat) begin
				rhat_q <= '1;
			end else if (sq_busy_q && sq_cnt_q == 6'd1) begin
				rhat_q <= sq_res_nx[RHAT_W-1:0];
			end
		end
		if (cmd.mm_latch) begin
			mm_q <= msum_q[MSW-1] ? (~q_mm + 1'b1) : q_mm;
		end
		if (cmd.vm_latch) begin
			vm_q <= quo;
		end
		if (cmd.mv_latch) begin
			mv_q <= quo[63:0];
		end
		if (cmd.t_latch) begin
			t_q <= quo;
		end
	end

	// sticky stop, evaluation count and result register
	logic              stopped_q;
	logic [EVAL_W-1:0] evals_q;
	logic              stop_now;
	logic              out_vld_q;

	assign stop_now = (ev_valid_q && (32'(rhat_q) <= 32'(thr_q))) || all_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q <= 1'b0;
			evals_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				stopped_q <= stopped_q | stop_now;
				evals_q   <= evals_q + EVAL_W'(1);
				out_vld_q <= 1'b1;
			end else if (res_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_r_hat       <= ev_valid_q ? rhat_q : '0;
			res_r_hat_valid <= ev_valid_q;
			res_total_draws <= total_q;
			res_stop        <= stopped_q | stop_now;
			res_eval_count  <= evals_q + EVAL_W'(1);
		end
	end

	assign res_valid = out_vld_q;

	// status to the sequencer
	assign st.op        = op_q;
	assign st.obs_ign   = stopped_q || (32'(chain_q) >= 32'(m_act));
	assign st.rd_full   = chain_full;
	assign st.idx_last  = idx_q == CW'(m_act - MW'(1));
	assign st.div_busy  = div_busy;
	assign st.mul_busy  = mul_busy_q;
	assign st.sqrt_busy = sq_busy_q;
	assign st.ev_valid  = ev_valid_q;
	assign st.vm_big    = |vm_q[NUM_W-1:96];
	assign st.t_big     = (|t_q[NUM_W-1:64]) || (t_q[63:0] > T_LIMIT);
	assign st.out_busy  = out_vld_q && !res_ready;

endmodule

// ===== rtl/rhat_convergence_monitor.sv =====
// ----------------------------------------------------------------------------
// rhat_convergence_monitor
// Gelman-Rubin R-hat monitor with per-chain Welford statistics.
// ----------------------------------------------------------------------------
// An observe word updates one chain's count, mean and sum of squared
// deviations: a statistics read, a 49-step division of the deviation by the
// new count, then a 49-step shift-add multiply before the write-back. It is
// ignored after a stop, for a chain index beyond the chains in use, or for a
// full chain. An evaluate word returns one result: one pass over the chains
// sums counts and means, a 64-step division forms the mean of means, a second
// pass runs the squared deviation of each chain mean alongside its 64-step
// variance division, then three 128-step divisions and a 32-step square root
// finish R-hat, unless a chain has under two draws or R-hat saturates. The
// radix-2 divider is shared by all divisions. One word is worked on at a
// time; a new word is taken while a result still waits on the output.
// Per-chain state clears at reset through valid bits, with no clearing pass.
// Configuration must be written only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rhat_convergence_monitor import rcm_pkg::*; #(
	parameter int MAX_CHAINS = 64,
	parameter int COUNT_BITS = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFGI_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	rcm_in_if.sink            item,
	rcm_out_if.source         result
);

	cmd_t    cmd;
	status_t st;

	rcm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item.valid),
		.st(st),
		.item_ready(item.ready),
		.cmd(cmd)
	);

	rcm_dp #(.MAX_CHAINS(MAX_CHAINS), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_operation(item.operation),
		.in_chain_index(item.chain_index),
		.in_sample_x(item.sample_x),
		.res_ready(result.ready),
		.res_valid(result.valid),
		.res_r_hat(result.r_hat),
		.res_r_hat_valid(result.r_hat_valid),
		.res_total_draws(result.total_draws),
		.res_stop(result.stop),
		.res_eval_count(result.eval_count),
		.cmd(cmd),
		.st(st)
	);

endmodule
